// ===== design/nps_pkg.sv =====
// Shared widths, types and constants of the priority scheduler.
// No dependencies; every other design file imports this package.
package nps_pkg;

   localparam int MAX_JOBS = 64;
   localparam int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int CNT_W    = $clog2(MAX_JOBS + 1);

   localparam int ARR_W  = 16;
   localparam int BUR_W  = 16;
   localparam int PRI_W  = 8;
   localparam int JIDX_W = 6;
   localparam int TIME_W = 23;
   localparam int SUM_W  = 29;

   // Partial result of the selection scan, handed from cell to cell.
   typedef struct packed {
      logic             found;
      logic [PRI_W-1:0] best_prio;
      logic [IDX_W-1:0] best_idx;
      logic [ARR_W-1:0] best_arr;
      logic [BUR_W-1:0] best_burst;
      logic             pend;
      logic [ARR_W-1:0] earliest;
   } token_type;

   // Broadcast control from the sequencer to every cell.
   typedef struct packed {
      logic              load;
      logic              clear;
      logic              mark;
      logic [IDX_W-1:0]  sel;
      logic [CNT_W-1:0]  count;
      logic [TIME_W-1:0] cur_time;
      logic [ARR_W-1:0]  arrival;
      logic [BUR_W-1:0]  burst;
      logic [PRI_W-1:0]  prio;
   } cell_ctl_type;

   localparam token_type TOKEN_EMPTY = '0;

endpackage

// ===== design/nps_if.sv =====
// Valid/ready channel interfaces for job beats and result beats.
// Depends on nps_pkg for the field widths.
interface nps_req_if;
   import nps_pkg::*;

   logic             valid;
   logic             ready;
   logic [ARR_W-1:0] arrival_time;
   logic [BUR_W-1:0] burst_time;
   logic [PRI_W-1:0] job_priority;
   logic             last;

   modport source (output valid, output arrival_time, output burst_time,
                   output job_priority, output last, input ready);
   modport sink (input valid, input arrival_time, input burst_time,
                 input job_priority, input last, output ready);
endinterface

interface nps_rsp_if;
   import nps_pkg::*;

   logic              valid;
   logic              ready;
   logic [JIDX_W-1:0] job_index;
   logic [TIME_W-1:0] completion_time;
   logic [TIME_W-1:0] turnaround_time;
   logic [TIME_W-1:0] waiting_time;
   logic [SUM_W-1:0]  total_turnaround;
   logic [SUM_W-1:0]  total_waiting;
   logic              final_res;

   modport source (output valid, output job_index, output completion_time,
                   output turnaround_time, output waiting_time,
                   output total_turnaround, output total_waiting,
                   output final_res, input ready);
   modport sink (input valid, input job_index, input completion_time,
                 input turnaround_time, input waiting_time,
                 input total_turnaround, input total_waiting,
                 input final_res, output ready);
endinterface

// ===== design/non_preemptive_priority_scheduler.sv =====
// Non-preemptive priority scheduler. Job beats load one per cycle into a chain of
// MAX_JOBS cells; the beat flagged last starts the schedule and the request side
// stays not ready until the last result has been loaded into the result register.
// Each decision sends a selection token down the whole chain, one cell per cycle;
// a pick then passes the completion, turnaround and waiting states and loads the
// result register once the previous result is taken. When no unfinished job has
// arrived, the scan moves the clock to the earliest pending arrival and scans again.
// Depends on nps_pkg, nps_if and nps_cell.
module non_preemptive_priority_scheduler (
   input logic       clock,
   input logic       reset,
   nps_req_if.sink   req_ch,
   nps_rsp_if.source rsp_ch
);
   import nps_pkg::*;

   localparam logic [2:0] ST_LOAD  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_COMP  = 3'd2;
   localparam logic [2:0] ST_TAT   = 3'd3;
   localparam logic [2:0] ST_WAIT  = 3'd4;
   localparam logic [2:0] ST_EMIT  = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  job_cnt_ff, job_cnt_in;
   logic [CNT_W-1:0]  fin_ff, fin_in, fin_next;
   logic [TIME_W-1:0] cur_ff, cur_in;
   logic [SUM_W-1:0]  sum_tat_ff, sum_tat_in, sum_tat_next;
   logic [SUM_W-1:0]  sum_wt_ff, sum_wt_in, sum_wt_next;
   logic [IDX_W-1:0]  pick_idx_ff, pick_idx_in;
   logic [ARR_W-1:0]  pick_arr_ff, pick_arr_in;
   logic [BUR_W-1:0]  pick_bur_ff, pick_bur_in;
   logic [TIME_W-1:0] comp_ff, comp_in;
   logic [TIME_W-1:0] tat_ff, tat_in;
   logic [TIME_W-1:0] wt_ff, wt_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [JIDX_W-1:0] rsp_idx_ff;
   logic [TIME_W-1:0] rsp_comp_ff, rsp_tat_ff, rsp_wt_ff;
   logic [SUM_W-1:0]  rsp_sum_tat_ff, rsp_sum_wt_ff;
   logic              rsp_final_ff;

   logic              accept, scan_done, emit_go, final_now;
   cell_ctl_type      ctl;
   token_type         chain [MAX_JOBS+1];

   assign chain[0] = TOKEN_EMPTY;

   for (genvar g = 0; g < MAX_JOBS; g++) begin : g_cell
      nps_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .my_index  (IDX_W'(g)),
         .ctl       (ctl),
         .tok_left  (chain[g]),
         .tok_right (chain[g+1])
      );
   end

   assign req_ch.ready = (state_ff == ST_LOAD);
   assign accept       = req_ch.valid && req_ch.ready;
   assign scan_done    = (cnt_ff == CNT_W'(MAX_JOBS));
   assign emit_go      = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ch.ready);
   assign fin_next     = fin_ff + CNT_W'(1);
   assign final_now    = (fin_next == job_cnt_ff);
   assign sum_tat_next = sum_tat_ff + SUM_W'(tat_ff);
   assign sum_wt_next  = sum_wt_ff + SUM_W'(wt_ff);

   always_comb begin
      ctl.load     = accept && (job_cnt_ff < CNT_W'(MAX_JOBS));
      ctl.clear    = emit_go && final_now;
      ctl.mark     = emit_go;
      ctl.sel      = (state_ff == ST_LOAD) ? job_cnt_ff[IDX_W-1:0] : pick_idx_ff;
      ctl.count    = job_cnt_ff;
      ctl.cur_time = cur_ff;
      ctl.arrival  = req_ch.arrival_time;
      ctl.burst    = req_ch.burst_time;
      ctl.prio     = req_ch.job_priority;
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      job_cnt_in  = job_cnt_ff;
      fin_in      = fin_ff;
      cur_in      = cur_ff;
      sum_tat_in  = sum_tat_ff;
      sum_wt_in   = sum_wt_ff;
      pick_idx_in = pick_idx_ff;
      pick_arr_in = pick_arr_ff;
      pick_bur_in = pick_bur_ff;
      comp_in     = comp_ff;
      tat_in      = tat_ff;
      wt_in       = wt_ff;
      case (state_ff)
         ST_LOAD: begin
            if (ctl.load) begin
               job_cnt_in = job_cnt_ff + CNT_W'(1);
            end
            if (accept && req_ch.last) begin
               state_in = ST_SCAN;
               cnt_in   = '0;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               cnt_in = '0;
               if (chain[MAX_JOBS].found) begin
                  pick_idx_in = chain[MAX_JOBS].best_idx;
                  pick_arr_in = chain[MAX_JOBS].best_arr;
                  pick_bur_in = chain[MAX_JOBS].best_burst;
                  state_in    = ST_COMP;
               end else begin
                  cur_in = TIME_W'(chain[MAX_JOBS].earliest);
               end
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_COMP: begin
            comp_in  = cur_ff + TIME_W'(pick_bur_ff);
            state_in = ST_TAT;
         end
         ST_TAT: begin
            tat_in   = comp_ff - TIME_W'(pick_arr_ff);
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            wt_in    = tat_ff - TIME_W'(pick_bur_ff);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit_go) begin
               if (final_now) begin
                  job_cnt_in = '0;
                  fin_in     = '0;
                  cur_in     = '0;
                  sum_tat_in = '0;
                  sum_wt_in  = '0;
                  state_in   = ST_LOAD;
               end else begin
                  fin_in     = fin_next;
                  cur_in     = comp_ff;
                  sum_tat_in = sum_tat_next;
                  sum_wt_in  = sum_wt_next;
                  cnt_in     = '0;
                  state_in   = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         job_cnt_ff   <= '0;
         fin_ff       <= '0;
         cur_ff       <= '0;
         sum_tat_ff   <= '0;
         sum_wt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         job_cnt_ff   <= job_cnt_in;
         fin_ff       <= fin_in;
         cur_ff       <= cur_in;
         sum_tat_ff   <= sum_tat_in;
         sum_wt_ff    <= sum_wt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pick_idx_ff <= pick_idx_in;
      pick_arr_ff <= pick_arr_in;
      pick_bur_ff <= pick_bur_in;
      comp_ff     <= comp_in;
      tat_ff      <= tat_in;
      wt_ff       <= wt_in;
      if (emit_go) begin
         rsp_idx_ff     <= JIDX_W'(pick_idx_ff);
         rsp_comp_ff    <= comp_ff;
         rsp_tat_ff     <= tat_ff;
         rsp_wt_ff      <= wt_ff;
         rsp_sum_tat_ff <= sum_tat_next;
         rsp_sum_wt_ff  <= sum_wt_next;
         rsp_final_ff   <= final_now;
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.job_index        = rsp_idx_ff;
   assign rsp_ch.completion_time  = rsp_comp_ff;
   assign rsp_ch.turnaround_time  = rsp_tat_ff;
   assign rsp_ch.waiting_time     = rsp_wt_ff;
   assign rsp_ch.total_turnaround = rsp_sum_tat_ff;
   assign rsp_ch.total_waiting    = rsp_sum_wt_ff;
   assign rsp_ch.final_res        = rsp_final_ff;

`ifndef SYNTHESIS
   a_last_stops_loading: assert property (@(posedge clock) disable iff (reset)
      accept && req_ch.last |=> !req_ch.ready)
      else $error("job beat accepted after the last flag");

   a_scan_sees_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && scan_done |-> chain[MAX_JOBS].pend)
      else $error("scan finished without any unfinished job");

   a_pick_in_list: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && scan_done && chain[MAX_JOBS].found
      |-> (CNT_W'(chain[MAX_JOBS].best_idx) < job_cnt_ff))
      else $error("picked job lies beyond the loaded list");

   a_finished_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> (fin_ff < job_cnt_ff))
      else $error("finished count reached the job count while scheduling");

   a_run_cleared: assert property (@(posedge clock) disable iff (reset)
      emit_go && final_now |=> (state_ff == ST_LOAD) && (job_cnt_ff == '0)
      && (cur_ff == '0) && (sum_tat_ff == '0))
      else $error("run state not cleared after the final result");
`endif

endmodule

// ===== design/nps_cell.sv =====
// One job slot of the scheduler chain: holds a job and folds it into the
// selection token passed on to the next cell. Depends on nps_pkg.
module nps_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [nps_pkg::IDX_W-1:0] my_index,
   input  nps_pkg::cell_ctl_type     ctl,
   input  nps_pkg::token_type        tok_left,
   output nps_pkg::token_type        tok_right
);
   import nps_pkg::*;

   logic [ARR_W-1:0] arr_ff, arr_in;
   logic [BUR_W-1:0] bur_ff, bur_in;
   logic [PRI_W-1:0] pri_ff, pri_in;
   logic             done_ff, done_in;
   token_type        tok_ff, tok_in;
   logic             hit, wr, live, arrived;

   always_comb begin
      hit     = (ctl.sel == my_index);
      wr      = ctl.load && hit;
      arr_in  = wr ? ctl.arrival : arr_ff;
      bur_in  = wr ? ctl.burst : bur_ff;
      pri_in  = wr ? ctl.prio : pri_ff;
      done_in = done_ff;
      if (ctl.clear || wr) begin
         done_in = 1'b0;
      end else if (ctl.mark && hit) begin
         done_in = 1'b1;
      end
      live    = (CNT_W'(my_index) < ctl.count) && !done_ff;
      arrived = live && ({{(TIME_W-ARR_W){1'b0}}, arr_ff} <= ctl.cur_time);
      tok_in  = tok_left;
      if (arrived && (!tok_left.found || pri_ff < tok_left.best_prio)) begin
         tok_in.found      = 1'b1;
         tok_in.best_prio  = pri_ff;
         tok_in.best_idx   = my_index;
         tok_in.best_arr   = arr_ff;
         tok_in.best_burst = bur_ff;
      end
      if (live && (!tok_left.pend || arr_ff < tok_left.earliest)) begin
         tok_in.pend     = 1'b1;
         tok_in.earliest = arr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
         tok_ff  <= TOKEN_EMPTY;
      end else begin
         done_ff <= done_in;
         tok_ff  <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      arr_ff <= arr_in;
      bur_ff <= bur_in;
      pri_ff <= pri_in;
   end

   assign tok_right = tok_ff;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the non-preemptive priority scheduler.
// Depends on nps_pkg, nps_if and the scheduler top level. The scoreboard class predicts
// the run order and the times of every job list and checks each result beat.
module testbench;
   import nps_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 600000;

   typedef struct packed {
      logic [JIDX_W-1:0] job_index;
      logic [TIME_W-1:0] completion_time;
      logic [TIME_W-1:0] turnaround_time;
      logic [TIME_W-1:0] waiting_time;
      logic [SUM_W-1:0]  total_turnaround;
      logic [SUM_W-1:0]  total_waiting;
      logic              final_res;
   } sched_beat_type;

   class sched_scoreboard;
      logic [ARR_W-1:0]  arrival_mem [MAX_JOBS];
      logic [BUR_W-1:0]  burst_mem [MAX_JOBS];
      logic [PRI_W-1:0]  prio_mem [MAX_JOBS];
      bit                done_mem [MAX_JOBS];
      int unsigned       jobs_held;
      logic [TIME_W-1:0] now_time;
      logic [SUM_W-1:0]  tat_sum;
      logic [SUM_W-1:0]  wait_sum;
      sched_beat_type    run_order_q [$];
      int unsigned       mismatches;

      function new();
         mismatches = 0;
         clear_list();
      endfunction

      function void clear_list();
         for (int i = 0; i < MAX_JOBS; i++) begin
            done_mem[i] = 1'b0;
         end
         jobs_held = 0;
         now_time  = '0;
         tat_sum   = '0;
         wait_sum  = '0;
      endfunction

      function int unsigned pending();
         return run_order_q.size();
      endfunction

      function void schedule_jobs();
         int unsigned       finished;
         int unsigned       pick;
         bit                found;
         bit                pend;
         logic [PRI_W-1:0]  best;
         logic [ARR_W-1:0]  earliest;
         logic [TIME_W-1:0] comp;
         logic [TIME_W-1:0] tat;
         logic [TIME_W-1:0] wt;
         sched_beat_type    beat;
         finished = 0;
         while (finished < jobs_held) begin
            found    = 1'b0;
            pend     = 1'b0;
            pick     = 0;
            best     = '0;
            earliest = '0;
            for (int i = 0; i < jobs_held; i++) begin
               if (!done_mem[i]) begin
                  if (TIME_W'(arrival_mem[i]) <= now_time && (!found || prio_mem[i] < best)) begin
                     found = 1'b1;
                     best  = prio_mem[i];
                     pick  = i;
                  end
                  if (!pend || arrival_mem[i] < earliest) begin
                     pend     = 1'b1;
                     earliest = arrival_mem[i];
                  end
               end
            end
            if (!found) begin
               now_time = TIME_W'(earliest);
            end else begin
               comp           = now_time + TIME_W'(burst_mem[pick]);
               tat            = comp - TIME_W'(arrival_mem[pick]);
               wt             = tat - TIME_W'(burst_mem[pick]);
               tat_sum        = tat_sum + SUM_W'(tat);
               wait_sum       = wait_sum + SUM_W'(wt);
               done_mem[pick] = 1'b1;
               finished++;
               now_time = comp;
               beat.job_index        = JIDX_W'(pick);
               beat.completion_time  = comp;
               beat.turnaround_time  = tat;
               beat.waiting_time     = wt;
               beat.total_turnaround = tat_sum;
               beat.total_waiting    = wait_sum;
               beat.final_res        = (finished == jobs_held);
               run_order_q.push_back(beat);
            end
         end
         clear_list();
      endfunction

      function void note_job(logic [ARR_W-1:0] arr, logic [BUR_W-1:0] bur,
                             logic [PRI_W-1:0] pri, logic is_last);
         if (jobs_held < MAX_JOBS) begin
            arrival_mem[jobs_held] = arr;
            burst_mem[jobs_held]   = bur;
            prio_mem[jobs_held]    = pri;
            done_mem[jobs_held]    = 1'b0;
            jobs_held++;
         end
         if (is_last) begin
            schedule_jobs();
         end
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s expected %0d actual %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(sched_beat_type got);
         sched_beat_type want;
         if (run_order_q.size() == 0) begin
            $error("Unexpected result beat for job_index %0d.", got.job_index);
            mismatches++;
            return;
         end
         want = run_order_q.pop_front();
         compare_field("job_index", 32'(want.job_index), 32'(got.job_index));
         compare_field("completion_time", 32'(want.completion_time),
                       32'(got.completion_time));
         compare_field("turnaround_time", 32'(want.turnaround_time),
                       32'(got.turnaround_time));
         compare_field("waiting_time", 32'(want.waiting_time), 32'(got.waiting_time));
         compare_field("total_turnaround", 32'(want.total_turnaround),
                       32'(got.total_turnaround));
         compare_field("total_waiting", 32'(want.total_waiting), 32'(got.total_waiting));
         compare_field("final_res", 32'(want.final_res), 32'(got.final_res));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   nps_req_if req_ch ();
   nps_rsp_if rsp_ch ();

   non_preemptive_priority_scheduler i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   sched_scoreboard sb = new();
   int unsigned     send_idle_pct  = 0;
   int unsigned     recv_stall_pct = 0;
   int unsigned     cycle_count    = 0;
   int unsigned     jobs_sent      = 0;

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      sched_beat_type beat;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            beat.job_index        = rsp_ch.job_index;
            beat.completion_time  = rsp_ch.completion_time;
            beat.turnaround_time  = rsp_ch.turnaround_time;
            beat.waiting_time     = rsp_ch.waiting_time;
            beat.total_turnaround = rsp_ch.total_turnaround;
            beat.total_waiting    = rsp_ch.total_waiting;
            beat.final_res        = rsp_ch.final_res;
            sb.check_result(beat);
         end
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   task automatic send_job(logic [ARR_W-1:0] arr, logic [BUR_W-1:0] bur,
                           logic [PRI_W-1:0] pri, logic is_last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.arrival_time <= arr;
      req_ch.burst_time   <= bur;
      req_ch.job_priority <= pri;
      req_ch.last         <= is_last;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sb.note_job(arr, bur, pri, is_last);
      jobs_sent++;
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic send_list(int unsigned n);
      int unsigned      arr_mode;
      int unsigned      bur_mode;
      int unsigned      pri_mode;
      logic [ARR_W-1:0] arr;
      logic [BUR_W-1:0] bur;
      logic [PRI_W-1:0] pri;
      arr_mode = $urandom_range(0, 2);
      bur_mode = $urandom_range(0, 1);
      pri_mode = $urandom_range(0, 1);
      for (int k = 0; k < n; k++) begin
         case (arr_mode)
            0: arr = ARR_W'($urandom_range(0, 65535));
            1: arr = ARR_W'($urandom_range(0, 300));
            default: arr = ARR_W'($urandom_range(0, 3) * 20000 + $urandom_range(0, 40));
         endcase
         bur = bur_mode ? BUR_W'($urandom_range(0, 65535)) : BUR_W'($urandom_range(0, 60));
         pri = pri_mode ? PRI_W'($urandom_range(0, 255)) : PRI_W'($urandom_range(0, 3));
         send_job(arr, bur, pri, k == n - 1);
      end
   endtask

   task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct,
                            int unsigned budget, bit with_overflow);
      int unsigned stop_at;
      drain_results();
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      stop_at        = jobs_sent + budget;
      if (with_overflow) begin
         send_list(MAX_JOBS + 2);
      end
      while (jobs_sent < stop_at) begin
         if ($urandom_range(0, 9) == 0) begin
            send_list($urandom_range(9, 20));
         end else begin
            send_list($urandom_range(1, 8));
         end
      end
   endtask

   initial begin
      req_ch.valid        <= 1'b0;
      req_ch.arrival_time <= '0;
      req_ch.burst_time   <= '0;
      req_ch.job_priority <= '0;
      req_ch.last         <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_job(16'd0, 16'd0, 8'd0, 1'b1);
      send_job(16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
      // Equal priorities all ready at once run in load order.
      send_job(16'd0, 16'd4, 8'd5, 1'b0);
      send_job(16'd0, 16'd3, 8'd5, 1'b0);
      send_job(16'd0, 16'd2, 8'd5, 1'b1);
      // A running job is never preempted by a more urgent arrival.
      send_job(16'd0, 16'd10, 8'd200, 1'b0);
      send_job(16'd1, 16'd5, 8'd100, 1'b0);
      send_job(16'd2, 16'd3, 8'd0, 1'b0);
      send_job(16'd2, 16'd0, 8'd0, 1'b1);
      // Idle gaps make the clock jump to the earliest pending arrival.
      send_job(16'd300, 16'd7, 8'd9, 1'b0);
      send_job(16'd10, 16'd5, 8'd9, 1'b0);
      send_job(16'd40000, 16'd1, 8'd1, 1'b0);
      send_job(16'hFFFF, 16'd0, 8'd0, 1'b1);
      send_job(16'h5555, 16'hAAAA, 8'h55, 1'b0);
      send_job(16'hAAAA, 16'h5555, 8'hAA, 1'b1);

      run_phase(0, 0, 90, 1'b1);
      run_phase(79, 0, 90, 1'b0);
      run_phase(0, 79, 90, 1'b0);
      run_phase(31, 31, 90, 1'b0);

      drain_results();
      repeat (2 * MAX_JOBS + 16) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
